>>> hw/rtl/lmm_pkg.sv
// ----------------------------------------------------------------------------
// lmm_pkg: shared types and constants of the latency monitor
// Kind codes, the empty-minimum marker, controller states and the status
// word of the iterative divider.
// ----------------------------------------------------------------------------
package lmm_pkg;

    localparam int unsigned DurW    = 32;
    localparam int unsigned SumW    = 64;
    localparam int unsigned KindW   = 2;
    // The divider retires this many quotient bits per cycle.
    localparam int unsigned DivBits = 2;
    localparam int unsigned DivSteps = SumW / DivBits;
    localparam int unsigned DivCntW  = $clog2(DivSteps);

    localparam logic [DurW-1:0] EMPTY_MIN = 32'hFFFF_FFFF;

    typedef enum logic [KindW-1:0] {
        KIND_MEASURED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_LOAD
    } lmm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hw/rtl/lmm_div.sv
// ----------------------------------------------------------------------------
// lmm_div: iterative 64-by-32 unsigned divider
// Restoring division, two quotient bits per cycle, one shared subtractor
// pair. The low 32 bits of the quotient are presented once done pulses.
// ----------------------------------------------------------------------------
module lmm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lmm_pkg::SumW-1:0]   dividend,
    input  logic [lmm_pkg::DurW-1:0]   divisor,
    output lmm_pkg::div_stat_t         stat,
    output logic [lmm_pkg::DurW-1:0]   quotient
);
    import lmm_pkg::*;

    logic [SumW-1:0]    acc_reg, acc_next;
    logic [DurW-1:0]    rem_reg, rem_next;
    logic [DurW-1:0]    dvs_reg;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DurW:0]      trial_a, trial_b;
    logic [DurW-1:0]    rem_a;
    logic               q_a, q_b;

    // Two dependent restoring steps per cycle.
    always_comb
    begin
        trial_a = {rem_reg, acc_reg[SumW-1]};
        q_a     = (trial_a >= {1'b0, dvs_reg});
        rem_a   = q_a ? DurW'(trial_a - {1'b0, dvs_reg}) : trial_a[DurW-1:0];
        trial_b = {rem_a, acc_reg[SumW-2]};
        q_b     = (trial_b >= {1'b0, dvs_reg});
        rem_next = q_b ? DurW'(trial_b - {1'b0, dvs_reg}) : trial_b[DurW-1:0];
        acc_next = {acc_reg[SumW-3:0], q_a, q_b};
        cnt_next = cnt_reg + 1'b1;
        busy_next = busy_reg && (cnt_reg != DivCntW'(DivSteps - 1));
        done_next = busy_reg && (cnt_reg == DivCntW'(DivSteps - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg[DurW-1:0];

endmodule

>>> hw/rtl/latency_min_max_avg_monitor.sv
// ----------------------------------------------------------------------------
// latency_min_max_avg_monitor: running latency statistics
// Keeps last, minimum, maximum, success and failure counts and a 64-bit
// sum of successful durations; reports them with the truncated average
// after every input word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_ready   kind, cost_us, ok
//  out       source     out_valid / out_ready last_us, min_us, max_us, avg_us,
//                                             ok_total, fail_total
//
//  An input word passes through these steps: the statistics update on
//  acceptance, the divider launch, the divider's iterative steps of two
//  quotient bits each, the divider's done signal, and the load of the
//  result register. With no successes the divide is skipped.
//  A new input word is accepted only once the last one has loaded its result.
//  Reset is asynchronous and returns every statistic to its cleared value.
//  A stalled result waits in the output register; the next input word is
//  still accepted and held back only at its own result load.
//
module latency_min_max_avg_monitor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lmm_pkg::KindW-1:0]   kind,
    input  logic [lmm_pkg::DurW-1:0]    cost_us,
    input  logic                        ok,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lmm_pkg::DurW-1:0]    last_us,
    output logic [lmm_pkg::DurW-1:0]    min_us,
    output logic [lmm_pkg::DurW-1:0]    max_us,
    output logic [lmm_pkg::DurW-1:0]    avg_us,
    output logic [lmm_pkg::DurW-1:0]    ok_total,
    output logic [lmm_pkg::DurW-1:0]    fail_total
);
    import lmm_pkg::*;

    lmm_state_t         state_reg, state_next;

    // Statistics proper.
    logic [DurW-1:0]    last_reg, last_next;
    logic [DurW-1:0]    min_reg, min_next;
    logic [DurW-1:0]    max_reg, max_next;
    logic [SumW-1:0]    sum_reg, sum_next;
    logic [DurW-1:0]    okc_reg, okc_next;
    logic [DurW-1:0]    failc_reg, failc_next;

    // Result register.
    logic               ov_reg, ov_next;
    logic [DurW-1:0]    o_last_reg, o_min_reg, o_max_reg, o_avg_reg;
    logic [DurW-1:0]    o_ok_reg, o_fail_reg;

    logic               in_acc;
    logic               load_out;
    logic               div_start;
    div_stat_t          div_stat;
    logic [DurW-1:0]    div_q;
    kind_t              kind_in;

    assign kind_in = kind_t'(kind);
    assign in_acc  = in_valid && in_ready;

    lmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (okc_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Statistics update for the word being accepted.
    always_comb
    begin
        last_next  = last_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        okc_next   = okc_reg;
        failc_next = failc_reg;
        case (kind_in)
            KIND_MEASURED:
            begin
                last_next = cost_us;
                if (cost_us < min_reg)
                    min_next = cost_us;
                if (cost_us > max_reg)
                    max_next = cost_us;
                if (ok)
                begin
                    okc_next = okc_reg + 1'b1;
                    sum_next = sum_reg + {{(SumW-DurW){1'b0}}, cost_us};
                end
                else
                begin
                    failc_next = failc_reg + 1'b1;
                end
            end
            KIND_REJECTED:
            begin
                failc_next = failc_reg + 1'b1;
            end
            KIND_CLEAR:
            begin
                last_next  = '0;
                min_next   = EMPTY_MIN;
                max_next   = '0;
                sum_next   = '0;
                okc_next   = '0;
                failc_next = '0;
            end
            default:
            begin
                // The unused kind leaves every statistic as it is.
            end
        endcase
    end

    // Sequencer: update, divide unless there are no successes, then wait for room in the result register.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                if (okc_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!ov_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            last_reg  <= '0;
            min_reg   <= EMPTY_MIN;
            max_reg   <= '0;
            sum_reg   <= '0;
            okc_reg   <= '0;
            failc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (in_acc)
            begin
                last_reg  <= last_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
                okc_reg   <= okc_next;
                failc_reg <= failc_next;
            end
        end
    end

    // The empty minimum reads as zero; the average is zero with no successes.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_last_reg <= last_reg;
            o_min_reg  <= (min_reg == EMPTY_MIN) ? '0 : min_reg;
            o_max_reg  <= max_reg;
            o_avg_reg  <= (okc_reg == '0) ? '0 : div_q;
            o_ok_reg   <= okc_reg;
            o_fail_reg <= failc_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign last_us    = o_last_reg;
    assign min_us     = o_min_reg;
    assign max_us     = o_max_reg;
    assign avg_us     = o_avg_reg;
    assign ok_total   = o_ok_reg;
    assign fail_total = o_fail_reg;

    // An accepted word keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted again straight after a word");

    // With no successes the divide is skipped.
    a_skip_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH && okc_reg == '0) |=> (state_reg == ST_LOAD))
        else $error("divide launched with a zero success count");

    // A launched divide keeps the divider busy on the following cycle.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy)
        else $error("divider not busy after a launch");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    // The reported minimum never shows the empty marker.
    a_min_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_us != EMPTY_MIN))
        else $error("empty minimum marker reported");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the latency statistics monitor
// A short table of directed words covers reset, the extremes, every kind and
// the special cases. A long run of random words follows, with bursty input
// and a receiver that stalls on a pattern. Every result word is compared,
// field by field, with a hand-read result or a running model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import lmm_pkg::*;

    // Number of random words after the directed table.
    localparam int unsigned RandomWords  = 1830;
    // The sender holds off until every result has come back this often.
    localparam int unsigned DrainEvery   = 400;
    // Margin after the last result in which a stray result word would still be caught.
    localparam int unsigned SettleCycles = 60;
    // The slowest legal run is roughly 1850 words, each with the block's own
    // work, the longest sender gap and a full receiver stall pattern; the limit
    // sits well above that.
    localparam int unsigned CycleLimit   = 1000000;

    localparam logic [DurW-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // One result word, in the order of the output ports.
    typedef struct packed {
        logic [DurW-1:0] last_us;
        logic [DurW-1:0] min_us;
        logic [DurW-1:0] max_us;
        logic [DurW-1:0] avg_us;
        logic [DurW-1:0] ok_total;
        logic [DurW-1:0] fail_total;
    } stats_t;

    // One input word; where typed is set, want holds the result read off by
    // hand, otherwise the running model supplies it.
    typedef struct packed {
        kind_t           k;
        logic [DurW-1:0] cost;
        logic            ok;
        logic            typed;
        stats_t          want;
    } stim_row_t;

    localparam stats_t NO_CHECK   = '0;
    localparam stats_t ZERO_STATS = '0;
    localparam int unsigned DirectedRows = 23;

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [DirectedRows] = '{
        // Straight after reset an unused kind reports the cleared statistics.
        '{KIND_UNUSED,   32'h0,        1'b0, 1'b1, ZERO_STATS},
        // A rejected call only counts a failure, whatever cost and ok hold.
        '{KIND_REJECTED, ALL_ONES,     1'b1, 1'b1,
          '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1}},
        // A clear ignores its payload and returns everything to zero.
        '{KIND_CLEAR,    ALL_ONES,     1'b1, 1'b1, ZERO_STATS},
        // An all-ones sample looks like the empty minimum, so min reads 0.
        '{KIND_MEASURED, ALL_ONES,     1'b1, 1'b1,
          '{ALL_ONES, 32'h0, ALL_ONES, ALL_ONES, 32'h1, 32'h0}},
        // A failed zero-length transfer sets the minimum but not the sum.
        '{KIND_MEASURED, 32'h0,        1'b0, 1'b1,
          '{32'h0, 32'h0, ALL_ONES, ALL_ONES, 32'h1, 32'h1}},
        // Two all-ones successes: the sum passes 32 bits, the average does not.
        '{KIND_MEASURED, ALL_ONES,     1'b1, 1'b1,
          '{ALL_ONES, 32'h0, ALL_ONES, ALL_ONES, 32'h2, 32'h1}},
        // The unused kind changes nothing and ignores its payload.
        '{KIND_UNUSED,   32'h0000_1234, 1'b1, 1'b1,
          '{ALL_ONES, 32'h0, ALL_ONES, ALL_ONES, 32'h2, 32'h1}},
        '{KIND_CLEAR,    32'h0,        1'b0, 1'b1, ZERO_STATS},
        // Smallest successful transfer.
        '{KIND_MEASURED, 32'h0,        1'b1, 1'b1,
          '{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0}},
        '{KIND_CLEAR,    ALL_ONES,     1'b0, 1'b1, ZERO_STATS},
        // A failed all-ones transfer leaves the minimum empty and no average.
        '{KIND_MEASURED, ALL_ONES,     1'b0, 1'b1,
          '{ALL_ONES, 32'h0, ALL_ONES, 32'h0, 32'h0, 32'h1}},
        '{KIND_MEASURED, 32'd100,      1'b1, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'd7,        1'b1, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'h8000_0000, 1'b1, 1'b0, NO_CHECK},
        '{KIND_REJECTED, 32'd55,       1'b0, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'd1,        1'b0, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'hAAAA_AAAA, 1'b1, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'h5555_5555, 1'b1, 1'b0, NO_CHECK},
        '{KIND_UNUSED,   ALL_ONES,     1'b0, 1'b0, NO_CHECK},
        '{KIND_MEASURED, 32'hFFFF_FFFE, 1'b1, 1'b0, NO_CHECK},
        '{KIND_CLEAR,    32'h1234_5678, 1'b1, 1'b1, ZERO_STATS},
        '{KIND_REJECTED, 32'h0,        1'b0, 1'b1,
          '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1}},
        '{KIND_MEASURED, 32'd3,        1'b1, 1'b0, NO_CHECK}
    };

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [KindW-1:0]     kind      = KIND_MEASURED;
    logic [DurW-1:0]      cost_us   = '0;
    logic                 ok        = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DurW-1:0]      last_us;
    logic [DurW-1:0]      min_us;
    logic [DurW-1:0]      max_us;
    logic [DurW-1:0]      avg_us;
    logic [DurW-1:0]      ok_total;
    logic [DurW-1:0]      fail_total;

    always #5 clk = ~clk;

    latency_min_max_avg_monitor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .cost_us    (cost_us),
        .ok         (ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .last_us    (last_us),
        .min_us     (min_us),
        .max_us     (max_us),
        .avg_us     (avg_us),
        .ok_total   (ok_total),
        .fail_total (fail_total)
    );

    // ------------------------------------------------------------------------
    // Running statistics, kept independently of the block
    // ------------------------------------------------------------------------
    logic [DurW-1:0] last_q;
    logic [DurW-1:0] min_q;
    logic [DurW-1:0] max_q;
    logic [SumW-1:0] sum_q;
    logic [DurW-1:0] okcnt_q;
    logic [DurW-1:0] failcnt_q;

    // Results still owed by the block, oldest first.
    stats_t      pending_stats [$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;
    int unsigned kind_seen [4] = '{0, 0, 0, 0};

    function automatic void clear_running_stats();
        last_q    = '0;
        min_q     = EMPTY_MIN;
        max_q     = '0;
        sum_q     = '0;
        okcnt_q   = '0;
        failcnt_q = '0;
    endfunction

    // Applies one accepted word to the running statistics and returns the
    // result word the block should report for it.
    function automatic stats_t next_stats(kind_t k, logic [DurW-1:0] c, logic o);
        stats_t          s;
        logic [SumW-1:0] quotient;
        case (k)
            KIND_MEASURED:
            begin
                last_q = c;
                if (c < min_q)
                    min_q = c;
                if (c > max_q)
                    max_q = c;
                if (o)
                begin
                    okcnt_q = okcnt_q + 1'b1;
                    sum_q   = sum_q + {{(SumW-DurW){1'b0}}, c};
                end
                else
                    failcnt_q = failcnt_q + 1'b1;
            end
            KIND_REJECTED:
                failcnt_q = failcnt_q + 1'b1;
            KIND_CLEAR:
                clear_running_stats();
            default:
                ;
        endcase
        // The average is the truncated quotient cut down to 32 bits.
        quotient = (okcnt_q != '0) ? sum_q / {{(SumW-DurW){1'b0}}, okcnt_q} : '0;
        s.last_us    = last_q;
        s.min_us     = (min_q == EMPTY_MIN) ? '0 : min_q;
        s.max_us     = max_q;
        s.avg_us     = quotient[DurW-1:0];
        s.ok_total   = okcnt_q;
        s.fail_total = failcnt_q;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Presents one word and waits for the handshake. Called at a rising edge;
    // valid is not lowered here, so back-to-back words keep it high.
    task automatic send_word(input stim_row_t r);
        stats_t predicted;
        kind     <= r.k;
        cost_us  <= r.cost;
        ok       <= r.ok;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = next_stats(r.k, r.cost, r.ok);
        pending_stats.push_back(r.typed ? r.want : predicted);
        kind_seen[r.k]++;
    endtask

    // Random words: mostly measured transfers, with failures, rejected calls,
    // the unused kind, and clears often enough that the empty minimum and the
    // zero average come back many times. The costs mix small values, the
    // extremes, single set bits and fully random words.
    function automatic stim_row_t random_word();
        stim_row_t   r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            r.k = KIND_MEASURED;
        else if (pick < 90)
            r.k = KIND_REJECTED;
        else if (pick < 94)
            r.k = KIND_UNUSED;
        else
            r.k = KIND_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            r.cost = $urandom_range(0, 255);
        else if (pick < 20)
        begin
            case ($urandom_range(0, 3))
                0:       r.cost = 32'h0;
                1:       r.cost = 32'h1;
                2:       r.cost = 32'hFFFF_FFFE;
                default: r.cost = ALL_ONES;
            endcase
        end
        else if (pick < 30)
            r.cost = 32'h1 << $urandom_range(0, 31);
        else
            r.cost = $urandom;
        r.ok    = ($urandom_range(0, 3) != 0);
        r.typed = 1'b0;
        r.want  = NO_CHECK;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // The receiver walks a 16-bit ready pattern and draws a fresh one at
    // the end of each: sometimes always ready, sometimes a full stall, most
    // often a random mix.
    logic [15:0] ready_pattern = '1;
    logic [3:0]  pattern_pos   = '0;

    always @(posedge clk)
    begin : ready_gen
        logic [15:0] fresh;
        if (pattern_pos == '0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: fresh = '1;
                3:       fresh = '0;
                default: fresh = 16'($urandom);
            endcase
            ready_pattern <= fresh;
            out_ready     <= fresh[0];
        end
        else
            out_ready <= ready_pattern[pattern_pos];
        pattern_pos <= pattern_pos + 1'b1;
    end

    function automatic void check_field(string name, logic [DurW-1:0] want,
                                        logic [DurW-1:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s mismatch: expected %h, got %h", name, want, got);
        end
    endfunction

    // Every accepted result word is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        stats_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stats.size() == 0)
            begin
                errors++;
                $error("result word with nothing pending: last_us %h fail_total %h",
                       last_us, fail_total);
            end
            else
            begin
                want = pending_stats.pop_front();
                results_seen++;
                check_field("last_us",    want.last_us,    last_us);
                check_field("min_us",     want.min_us,     min_us);
                check_field("max_us",     want.max_us,     max_us);
                check_field("avg_us",     want.avg_us,     avg_us);
                check_field("ok_total",   want.ok_total,   ok_total);
                check_field("fail_total", want.fail_total, fail_total);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycles, pending_stats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned sent;
        int unsigned burst;
        clear_running_stats();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with the odd gap so that words land in every phase.
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i]);
            if ($urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end

        // Let the block run dry before the random part starts.
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);

        // Random words in bursts; now and then a long burst with no idling,
        // and every so often a full drain of the results.
        sent = 0;
        while (sent < RandomWords)
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            for (int unsigned b = 0; b < burst && sent < RandomWords; b++)
            begin
                send_word(random_word());
                sent++;
                if (sent % DrainEvery == 0)
                begin
                    in_valid <= 1'b0;
                    while (pending_stats.size() != 0)
                        @(posedge clk);
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 50)) @(posedge clk);
            end
        end

        // Wind down: wait for the last results, then a little longer so that
        // any stray word from the block would still be caught.
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        $display("Sent %0d words: %0d measured, %0d rejected, %0d clears, %0d unused kind.",
                 kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
                 kind_seen[KIND_MEASURED], kind_seen[KIND_REJECTED],
                 kind_seen[KIND_CLEAR], kind_seen[KIND_UNUSED]);
        $display("Compared %0d result words field by field; %0d mismatches found.",
                 results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
